[sv/rotation_matrix_to_quaternion_assert.svh]
// assertion macros used by the rotation matrix to quaternion back end
`ifndef ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RMQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define RMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/rmq_pkg.sv]
// shared types and constants for the rotation matrix to quaternion block
package rmq_pkg;

    // quaternion component slots, also the lane order of the back end
    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2,
        AXIS_W = 2'd3
    } t_axis;

    // classification of one word, travels with it through queue and pipeline
    typedef struct packed {
        logic  invalid;
        t_axis root_sel;
    } t_cls;

    localparam int NUM_LANES   = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

endpackage

[sv/rmq_front.sv]
// front end: classifies a matrix, forms root argument and lane terms, queues them
module rmq_front #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [9*DATA_WIDTH-1:0]           i_mat,
    output logic                              o_q_valid,
    input  logic                              i_q_pop,
    output rmq_pkg::t_cls                     o_q_cls,
    output logic [DATA_WIDTH:0]               o_q_arg,
    output logic [4*(DATA_WIDTH+2)-1:0]       o_q_diff
);
    import rmq_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = W - 2;
    localparam int AW = W + 3;
    localparam int DW = W + 2;
    localparam int EW = $bits(t_cls) + (W + 1) + 4 * DW;

    logic signed [AW-1:0] m [0:8];
    logic signed [AW-1:0] one_v, tr, arg, mii, mjj, mkk;
    logic signed [AW-1:0] dx, dy, dz, s01, s02, s12;
    logic                 trace_pos;
    t_axis                diag_sel;
    t_cls                 cls;
    logic [4*DW-1:0]      diff;
    logic [EW-1:0]        entry;

    logic [EW-1:0]          r_mem [0:QUEUE_DEPTH-1];
    logic [QUEUE_PTR_W-1:0] r_wr, r_rd;
    logic [QUEUE_PTR_W:0]   r_cnt;
    logic                   push;

    // unpack and sign-extend the nine entries
    always_comb begin
        for (int n = 0; n < 9; n++) begin
            m[n] = AW'($signed(i_mat[n*W +: W]));
        end
    end

    // trace test and largest diagonal entry
    always_comb begin
        one_v     = AW'(1) <<< F;
        tr        = m[0] + m[4] + m[8];
        trace_pos = tr > 0;
        diag_sel  = AXIS_X;
        if (m[4] > m[0]) begin
            diag_sel = AXIS_Y;
        end
        if (m[8] > ((diag_sel == AXIS_Y) ? m[4] : m[0])) begin
            diag_sel = AXIS_Z;
        end
    end

    // off-diagonal sums and differences
    always_comb begin
        dx  = m[5] - m[7];
        dy  = m[6] - m[2];
        dz  = m[1] - m[3];
        s01 = m[1] + m[3];
        s02 = m[2] + m[6];
        s12 = m[5] + m[7];
    end

    // lane terms per branch, root lane carries zero
    always_comb begin
        mii = m[0];
        mjj = m[4];
        mkk = m[8];
        diff = '0;
        case (diag_sel)
            AXIS_X: begin
                diff = {DW'(dx), DW'(s02), DW'(s01), DW'(0)};
            end
            AXIS_Y: begin
                mii  = m[4];
                mjj  = m[8];
                mkk  = m[0];
                diff = {DW'(dy), DW'(s12), DW'(0), DW'(s01)};
            end
            AXIS_Z: begin
                mii  = m[8];
                mjj  = m[0];
                mkk  = m[4];
                diff = {DW'(dz), DW'(0), DW'(s12), DW'(s02)};
            end
            default: begin
                diff = '0;
            end
        endcase
        cls.root_sel = diag_sel;
        arg          = mii - mjj - mkk + one_v;
        if (trace_pos) begin
            diff         = {DW'(0), DW'(dz), DW'(dy), DW'(dx)};
            cls.root_sel = AXIS_W;
            arg          = tr + one_v;
        end
        cls.invalid = !trace_pos && (arg <= 0);
        if (cls.invalid) begin
            arg = '0;
        end
        entry = {cls, arg[W:0], diff};
    end

    // short queue towards the back end
    assign o_ready   = r_cnt != (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
    assign o_q_valid = r_cnt != '0;
    assign push      = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_q_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QUEUE_PTR_W+1)'(push) - (QUEUE_PTR_W+1)'(i_q_pop);
        end
    end

    assign {o_q_cls, o_q_arg, o_q_diff} = r_mem[r_rd];

endmodule

[sv/rmq_back.sv]
// back end: pipelined square root, four lane dividers, saturation and output word
module rmq_back #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    output logic                        o_q_pop,
    input  rmq_pkg::t_cls               i_q_cls,
    input  logic [DATA_WIDTH:0]         i_q_arg,
    input  logic [4*(DATA_WIDTH+2)-1:0] i_q_diff,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [4*DATA_WIDTH-1:0]     o_quat,
    output logic                        o_invalid
);
    import rmq_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = W - 2;
    localparam int SH = F - 2;
    localparam int DW = W + 2;
    localparam int NB = 2 * W;
    localparam int RW = W + 3;
    localparam int NW = 2 * W - 2;
    localparam logic [NW-1:0] HI_Q = NW'((64'd1 << (W - 1)) - 64'd1);
    localparam logic [NW-1:0] LO_Q = NW'(64'd1 << (W - 1));

    logic adv;

    // square root stages
    logic [NB-1:0]   r_sq_n    [0:W];
    logic [RW-1:0]   r_sq_rem  [0:W];
    logic [W-1:0]    r_sq_root [0:W];
    logic [4*DW-1:0] r_sq_d    [0:W];
    t_cls            r_sq_cls  [0:W];
    logic            r_sq_v    [0:W];

    // divider stages
    logic [3:0][NW-1:0] r_dv_num [0:NW];
    logic [3:0][W:0]    r_dv_rem [0:NW];
    logic [3:0][NW-1:0] r_dv_quo [0:NW];
    logic [3:0]         r_dv_neg [0:NW];
    logic [W-1:0]       r_dv_div [0:NW];
    t_cls               r_dv_cls [0:NW];
    logic               r_dv_v   [0:NW];

    logic [3:0][W-1:0]  n_quat;
    logic [3:0][W-1:0]  r_quat;
    logic               r_out_v, r_out_inv;

    // whole pipeline moves when the output word is free or taken
    assign adv     = !r_out_v || i_ready;
    assign o_q_pop = adv && i_q_valid;

    // root stage 0 loads the queue head
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_n[0]    <= NB'(i_q_arg) << SH;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_d[0]    <= i_q_diff;
            r_sq_cls[0]  <= i_q_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (adv) begin
            r_sq_v[0] <= i_q_valid;
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < W; k++) begin : g_sqrt
        logic [RW-1:0] rem_sh, trial;
        logic          ge;

        always_comb begin
            rem_sh = {r_sq_rem[k][RW-3:0], r_sq_n[k][NB-1-2*k -: 2]};
            trial  = RW'({r_sq_root[k], 2'b01});
            ge     = rem_sh >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq_n[k+1]    <= r_sq_n[k];
                r_sq_rem[k+1]  <= ge ? rem_sh - trial : rem_sh;
                r_sq_root[k+1] <= {r_sq_root[k][W-2:0], ge};
                r_sq_d[k+1]    <= r_sq_d[k];
                r_sq_cls[k+1]  <= r_sq_cls[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end
    end

    // divider set-up: magnitude, sign and rounded numerator per lane
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_prep
        logic signed [DW-1:0] d;
        logic [DW-1:0]        mag;

        always_comb begin
            d   = $signed(r_sq_d[W][l*DW +: DW]);
            mag = d[DW-1] ? DW'(-d) : DW'(d);
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_num[0][l] <= (NW'(mag[W:0]) << SH) + NW'(r_sq_root[W] >> 1);
                r_dv_rem[0][l] <= '0;
                r_dv_quo[0][l] <= '0;
                r_dv_neg[0][l] <= d[DW-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dv_div[0] <= r_sq_root[W];
            r_dv_cls[0] <= r_sq_cls[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (adv) begin
            r_dv_v[0] <= r_sq_v[W];
        end
    end

    // one quotient bit per stage in every lane
    for (genvar k = 0; k < NW; k++) begin : g_div
        for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
            logic [W:0] rs;
            logic       ge;

            always_comb begin
                rs = {r_dv_rem[k][l][W-1:0], r_dv_num[k][l][NW-1-k]};
                ge = rs >= {1'b0, r_dv_div[k]};
            end

            always_ff @(posedge i_clk) begin
                if (adv) begin
                    r_dv_num[k+1][l] <= r_dv_num[k][l];
                    r_dv_rem[k+1][l] <= ge ? rs - {1'b0, r_dv_div[k]} : rs;
                    r_dv_quo[k+1][l] <= {r_dv_quo[k][l][NW-2:0], ge};
                    r_dv_neg[k+1][l] <= r_dv_neg[k][l];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_div[k+1] <= r_dv_div[k];
                r_dv_cls[k+1] <= r_dv_cls[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_dv_v[k+1] <= r_dv_v[k];
            end
        end
    end

    // saturation and root lane selection
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            if (r_dv_cls[NW].invalid) begin
                n_quat[l] = '0;
            end else if (t_axis'(l) == r_dv_cls[NW].root_sel) begin
                n_quat[l] = (NW'(r_dv_div[NW]) > HI_Q) ? HI_Q[W-1:0] : r_dv_div[NW];
            end else if (r_dv_neg[NW][l]) begin
                n_quat[l] = (r_dv_quo[NW][l] > LO_Q) ? LO_Q[W-1:0]
                                                     : W'(-r_dv_quo[NW][l]);
            end else begin
                n_quat[l] = (r_dv_quo[NW][l] > HI_Q) ? HI_Q[W-1:0]
                                                     : r_dv_quo[NW][l][W-1:0];
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_quat    <= n_quat;
            r_out_inv <= r_dv_cls[NW].invalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= r_dv_v[NW];
        end
    end

    assign o_valid   = r_out_v;
    assign o_quat    = r_quat;
    assign o_invalid = r_out_inv;

    `include "rotation_matrix_to_quaternion_assert.svh"

    `RMQ_ASSERT_NOW(a_pop_needs_word, o_q_pop, i_q_valid, "pop from empty queue")
    `RMQ_ASSERT_NOW(a_invalid_zero, r_out_v && r_out_inv, r_quat == '0, "flagged word not zero")
    `RMQ_ASSERT_NEXT(a_root_to_div, adv && r_sq_v[W], r_dv_v[0], "word lost after root")

endmodule

[sv/rotation_matrix_to_quaternion.sv]
// top level: rotation matrix to quaternion, classifying front end and arithmetic back end
//
// channel    dir  handshake              payload
// s (matrix) in   i_s_tvalid/o_s_tready  i_s_tdata: m_r0c0 .. m_r2c2
// m (quat)   out  o_m_tvalid/i_m_tready  o_m_tdata: quat_x..quat_w, o_m_tuser: root_invalid
//
// one matrix per cycle sustained while i_m_tready takes each output word; o_m_tvalid follows the
// accepting edge through the queue slot, DATA_WIDTH+1 root registers, 2*DATA_WIDTH-1 divider
// registers (set-up plus one per quotient bit) and the output word.
// i_rst_n is synchronous, active low, and empties queue and pipeline.
// a stalled output holds the back pipeline; the four-word queue keeps s ready until it fills.
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2, m_r2c0, m_r2c1, m_r2c2
    input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]     i_s_tdata,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // quat_x, quat_y, quat_z, quat_w
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]     o_m_tdata,
    // root_invalid
    output logic                                  o_m_tuser
);
    import rmq_pkg::*;

    localparam int W    = DATA_WIDTH;
    localparam int DW   = W + 2;
    localparam int OUTW = ((4*W+7)/8)*8;

    logic                q_valid, q_pop;
    t_cls                q_cls;
    logic [W:0]          q_arg;
    logic [4*DW-1:0]     q_diff;
    logic [4*W-1:0]      quat;

    // classify and queue
    rmq_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_mat    (i_s_tdata[9*W-1:0]),
        .o_q_valid(q_valid),
        .i_q_pop  (q_pop),
        .o_q_cls  (q_cls),
        .o_q_arg  (q_arg),
        .o_q_diff (q_diff)
    );

    // root, divide, saturate
    rmq_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .o_q_pop  (q_pop),
        .i_q_cls  (q_cls),
        .i_q_arg  (q_arg),
        .i_q_diff (q_diff),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_quat   (quat),
        .o_invalid(o_m_tuser)
    );

    assign o_m_tdata = OUTW'(quat);

endmodule
